>>> hdl/u8dsc_pkg.sv
// ----------------------------------------------------------------------------
// u8dsc_pkg
// Shared types and constants of the utf-8 decoder with script classification.
// ----------------------------------------------------------------------------
`default_nettype none

package u8dsc_pkg;

   localparam int unsigned CODE_W = 16;

   // code given in place of a bad or cut-off byte
   localparam logic [CODE_W-1:0] SUBST_CODE = 16'h003F;

   localparam logic [CODE_W-1:0] CYRILLIC_LO    = 16'h0400;
   localparam logic [CODE_W-1:0] CYRILLIC_HI    = 16'h04FF;
   localparam logic [CODE_W-1:0] ARABIC_LO      = 16'h0600;
   localparam logic [CODE_W-1:0] ARABIC_HI      = 16'h06FF;
   localparam logic [CODE_W-1:0] ARABIC_PRES_LO = 16'hFB50;
   localparam logic [CODE_W-1:0] ARABIC_PRES_HI = 16'hFEFF;

   typedef enum logic [1:0] {
      SCRIPT_LATIN    = 2'd0,
      SCRIPT_CYRILLIC = 2'd1,
      SCRIPT_ARABIC   = 2'd2
   } script_kind_type;

   // results caused by one request: subst_count '?' first, then the code
   typedef struct packed {
      logic [1:0]        subst_count;
      logic              has_main;
      logic [CODE_W-1:0] code;
      script_kind_type   kind_subst;
      script_kind_type   kind_main;
      logic              text_end;
   } entry_type;

   function automatic script_kind_type kind_of(input logic arabic, input logic cyrillic);
      script_kind_type kind;
      if (arabic) begin
         kind = SCRIPT_ARABIC;
      end else if (cyrillic) begin
         kind = SCRIPT_CYRILLIC;
      end else begin
         kind = SCRIPT_LATIN;
      end
      return kind;
   endfunction

endpackage

`default_nettype wire

>>> hdl/u8dsc_front.sv
// ----------------------------------------------------------------------------
// u8dsc_front
// Accepts text bytes, runs the utf-8 sequence decoder and the sticky script
// flags, and pushes one entry per request that causes any result.
// ----------------------------------------------------------------------------
`default_nettype none

module u8dsc_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [7:0]           req_tdata,   // data_byte
   input  wire logic                 req_tlast,   // end_of_text
   input  wire logic                 push_ready,
   output logic                      push_valid,
   output u8dsc_pkg::entry_type      push_entry
);

   localparam logic [1:0] LEN_NONE  = 2'd0;
   localparam logic [1:0] LEN_TWO   = 2'd2;
   localparam logic [1:0] LEN_THREE = 2'd3;

   logic [15:0] partial_ff, partial_in;
   logic [1:0]  held_ff, held_in;
   logic [1:0]  len_ff, len_in;
   logic        cyr_ff, cyr_in;
   logic        arab_ff, arab_in;

   logic        accept;
   logic [1:0]  subst_count;
   logic        has_main;
   logic [15:0] main_code;
   logic [15:0] cont_code;
   logic [1:0]  held_inc;
   logic        consumed;
   logic        arab_hit;
   logic        cyr_hit;
   logic        arab_new;
   logic        cyr_new;

   assign req_tready = push_ready;
   assign accept     = req_tvalid && push_ready;

   always_comb begin
      partial_in  = partial_ff;
      held_in     = held_ff;
      len_in      = len_ff;
      subst_count = 2'd0;
      has_main    = 1'b0;
      main_code   = '0;
      consumed    = 1'b0;
      cont_code   = {partial_ff[9:0], req_tdata[5:0]};
      held_inc    = held_ff + 2'd1;

      if (held_ff != 2'd0 && req_tdata[7:6] == 2'b10) begin
         consumed = 1'b1;
         if (held_inc >= len_ff) begin
            has_main   = 1'b1;
            main_code  = cont_code;
            partial_in = '0;
            held_in    = 2'd0;
            len_in     = LEN_NONE;
         end else begin
            partial_in = cont_code;
            held_in    = held_inc;
         end
      end else if (held_ff != 2'd0) begin
         // broken sequence: one '?' per held byte
         subst_count = held_ff;
         partial_in  = '0;
         held_in     = 2'd0;
         len_in      = LEN_NONE;
      end

      if (!consumed) begin
         if (req_tdata inside {[8'h00:8'h7F]}) begin
            has_main  = 1'b1;
            main_code = {8'h00, req_tdata};
         end else if (req_tdata inside {[8'hC0:8'hDF]}) begin
            partial_in = {11'b0, req_tdata[4:0]};
            held_in    = 2'd1;
            len_in     = LEN_TWO;
         end else if (req_tdata inside {[8'hE0:8'hEF]}) begin
            partial_in = {12'b0, req_tdata[3:0]};
            held_in    = 2'd1;
            len_in     = LEN_THREE;
         end else begin
            subst_count = subst_count + 2'd1;
         end
      end

      // cut off by end of text
      if (req_tlast) begin
         subst_count = subst_count + held_in;
         partial_in  = '0;
         held_in     = 2'd0;
         len_in      = LEN_NONE;
      end

      arab_hit = has_main &&
                 (main_code inside {[u8dsc_pkg::ARABIC_LO:u8dsc_pkg::ARABIC_HI],
                                    [u8dsc_pkg::ARABIC_PRES_LO:u8dsc_pkg::ARABIC_PRES_HI]});
      cyr_hit  = has_main &&
                 (main_code inside {[u8dsc_pkg::CYRILLIC_LO:u8dsc_pkg::CYRILLIC_HI]});
      arab_new = arab_ff || arab_hit;
      cyr_new  = cyr_ff || cyr_hit;
      arab_in  = req_tlast ? 1'b0 : arab_new;
      cyr_in   = req_tlast ? 1'b0 : cyr_new;
   end

   always_comb begin
      push_valid             = accept && (subst_count != 2'd0 || has_main);
      push_entry.subst_count = subst_count;
      push_entry.has_main    = has_main;
      push_entry.code        = main_code;
      push_entry.kind_subst  = u8dsc_pkg::kind_of(arab_ff, cyr_ff);
      push_entry.kind_main   = u8dsc_pkg::kind_of(arab_new, cyr_new);
      push_entry.text_end    = req_tlast;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= '0;
         held_ff    <= 2'd0;
         len_ff     <= LEN_NONE;
         cyr_ff     <= 1'b0;
         arab_ff    <= 1'b0;
      end else if (accept) begin
         partial_ff <= partial_in;
         held_ff    <= held_in;
         len_ff     <= len_in;
         cyr_ff     <= cyr_in;
         arab_ff    <= arab_in;
      end
   end

endmodule

`default_nettype wire

>>> hdl/u8dsc_queue.sv
// ----------------------------------------------------------------------------
// u8dsc_queue
// Short first-in first-out queue of decoded entries between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module u8dsc_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push_valid,
   output logic                      push_ready,
   input  wire u8dsc_pkg::entry_type push_entry,
   output logic                      head_valid,
   output u8dsc_pkg::entry_type      head_entry,
   input  wire logic                 pop
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
   localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

   u8dsc_pkg::entry_type entries_ff [DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready = (count_ff != CNT_FULL);
   assign head_valid = (count_ff != '0);
   assign head_entry = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_ONE;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_ONE;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_ONE;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

>>> hdl/u8dsc_back.sv
// ----------------------------------------------------------------------------
// u8dsc_back
// Expands each queued entry into its results, one per cycle while the result
// channel is not stalled, into the output register of the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module u8dsc_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 head_valid,
   input  wire u8dsc_pkg::entry_type head_entry,
   output logic                      pop,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [15:0]               rsp_tdata,   // code_point
   output logic [3:0]                rsp_tuser,   // substituted, script_kind[1:0], run_last
   output logic                      rsp_tlast    // text_done
);

   logic [1:0]  idx_ff, idx_in;
   logic        rsp_tvalid_ff;
   logic [15:0] code_ff, code_in;
   logic [3:0]  user_ff, user_in;
   logic        last_ff, last_in;

   logic [2:0]  total;
   logic [2:0]  idx_next;
   logic        is_subst;
   logic        is_last;
   logic        load;
   u8dsc_pkg::script_kind_type kind;

   always_comb begin
      total    = {1'b0, head_entry.subst_count} + {2'b00, head_entry.has_main};
      idx_next = {1'b0, idx_ff} + 3'd1;
      is_subst = (idx_ff < head_entry.subst_count);
      is_last  = (idx_next == total);
      load     = head_valid && (!rsp_tvalid_ff || rsp_tready);
      pop      = load && is_last;
      idx_in   = is_last ? 2'd0 : idx_next[1:0];
      kind     = is_subst ? head_entry.kind_subst : head_entry.kind_main;
      code_in  = is_subst ? u8dsc_pkg::SUBST_CODE : head_entry.code;
      user_in  = {is_last, kind, is_subst};
      last_in  = is_last && head_entry.text_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
         idx_ff        <= 2'd0;
      end else if (load) begin
         rsp_tvalid_ff <= 1'b1;
         idx_ff        <= idx_in;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         code_ff <= code_in;
         user_ff <= user_in;
         last_ff <= last_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = code_ff;
   assign rsp_tuser  = user_ff;
   assign rsp_tlast  = last_ff;

endmodule

`default_nettype wire

>>> hdl/utf8_decode_script_classify.sv
// ----------------------------------------------------------------------------
// utf8_decode_script_classify
// Utf-8 decoder for sequences of one to three bytes with Cyrillic / Arabic
// script classification; front decoder, entry queue, back result expander.
// ----------------------------------------------------------------------------
// path: each entry is stored in the entry queue, its results in the output register
// throughput: one request per cycle while the queue has room, one result per cycle
// while results are taken; the queue holds requests while the back end expands one
// reset: synchronous; clears the decoder state, script flags, queue and
// output valid
`default_nettype none

module utf8_decode_script_classify #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // data_byte
   input  wire logic        req_tlast,   // end_of_text
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // code_point
   output logic [3:0]       rsp_tuser,   // substituted, script_kind[1:0], run_last
   output logic             rsp_tlast    // text_done
);

   logic                 push_valid;
   logic                 push_ready;
   u8dsc_pkg::entry_type push_entry;
   logic                 head_valid;
   u8dsc_pkg::entry_type head_entry;
   logic                 pop;

   u8dsc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .push_ready (push_ready),
      .push_valid (push_valid),
      .push_entry (push_entry)
   );

   u8dsc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop)
   );

   u8dsc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // end of text always closes the results of its request
   a_done_is_run_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser[3])
      else $error("text_done without run_last");

   // substituted results carry the replacement code
   a_subst_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == u8dsc_pkg::SUBST_CODE)
      else $error("substituted result with wrong code");

   // a request that leaves nothing in flight cannot have results pending
   a_no_result_from_empty: assert property (@(posedge clock) disable iff (reset)
      !head_valid && !rsp_tvalid |=> !rsp_tvalid || $past(push_valid) == 1'b0)
      else $error("result appeared with empty queue");

endmodule

`default_nettype wire

>>> tb/sv/utf8_decode_script_classify_test.sv
// ----------------------------------------------------------------------------
// utf8_decode_script_classify_test
// Streams UTF-8 texts into the decoder one byte per request and checks every
// decoded code point, '?' substitution, script kind and the run/text markers
// against an in-bench decoder, under several idle and back-pressure patterns.
// ----------------------------------------------------------------------------
module utf8_decode_script_classify_test;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned HOLD_CYCLES  = 64;
   localparam int unsigned IDLE_LIMIT   = 5000;
   localparam int unsigned TAIL_CYCLES  = 20;
   localparam int unsigned PHASE_BYTES  = 25;

   typedef struct {
      logic [15:0]                code;
      logic                       subst;
      u8dsc_pkg::script_kind_type kind;
      logic                       run_last;
      logic                       done;
   } decoded_char_type;

   typedef struct {
      logic [7:0]  data;
      logic        last;
      int unsigned idle_pct;
      int unsigned stall_pct;
      bit          drain_first;
      bit          hold;
   } text_byte_type;

   class script_decode_checker;
      logic [15:0]      partial;
      int unsigned      held;
      int unsigned      seq_len;
      bit               cyrillic_seen;
      bit               arabic_seen;
      decoded_char_type step_chars[$];
      decoded_char_type expected_chars[$];
      int unsigned      errors;
      int unsigned      requests;
      int unsigned      texts;
      int unsigned      checked;
      int unsigned      substs;
      int unsigned      final_kinds[3];

      function new();
         partial = '0;
         held = 0;
         seq_len = 0;
         cyrillic_seen = 0;
         arabic_seen = 0;
         errors = 0;
         requests = 0;
         texts = 0;
         checked = 0;
         substs = 0;
         final_kinds = '{0, 0, 0};
      endfunction

      function int unsigned pending();
         return expected_chars.size();
      endfunction

      function void add_char(logic [15:0] code, logic subst);
         decoded_char_type c;
         // substitutes never mark a script
         if (!subst) begin
            if ((code >= u8dsc_pkg::ARABIC_LO && code <= u8dsc_pkg::ARABIC_HI) ||
                (code >= u8dsc_pkg::ARABIC_PRES_LO && code <= u8dsc_pkg::ARABIC_PRES_HI))
               arabic_seen = 1;
            if (code >= u8dsc_pkg::CYRILLIC_LO && code <= u8dsc_pkg::CYRILLIC_HI)
               cyrillic_seen = 1;
         end
         c.code = code;
         c.subst = subst;
         c.kind = arabic_seen ? u8dsc_pkg::SCRIPT_ARABIC :
                  (cyrillic_seen ? u8dsc_pkg::SCRIPT_CYRILLIC : u8dsc_pkg::SCRIPT_LATIN);
         c.run_last = 0;
         c.done = 0;
         step_chars = {step_chars, c};
      endfunction

      function void flush_held();
         while (held > 0) begin
            add_char(u8dsc_pkg::SUBST_CODE, 1'b1);
            held--;
         end
         seq_len = 0;
         partial = '0;
      endfunction

      function void note_byte(logic [7:0] b, logic eot);
         bit consumed;
         consumed = 0;
         step_chars.delete();
         requests++;
         if (held > 0) begin
            if (b[7:6] == 2'b10) begin
               partial = {partial[9:0], b[5:0]};
               held++;
               if (held >= seq_len) begin
                  add_char(partial, 1'b0);
                  held = 0;
                  seq_len = 0;
                  partial = '0;
               end
               consumed = 1;
            end else begin
               // broken sequence, the breaking byte is decoded below
               flush_held();
            end
         end
         if (!consumed) begin
            if (!b[7]) begin
               add_char({8'h00, b}, 1'b0);
            end else if (b[7:5] == 3'b110) begin
               partial = {11'd0, b[4:0]};
               held = 1;
               seq_len = 2;
            end else if (b[7:4] == 4'b1110) begin
               partial = {12'd0, b[3:0]};
               held = 1;
               seq_len = 3;
            end else begin
               add_char(u8dsc_pkg::SUBST_CODE, 1'b1);
            end
         end
         if (eot) begin
            flush_held();
            if (step_chars.size() > 0)
               step_chars[step_chars.size()-1].done = 1;
            cyrillic_seen = 0;
            arabic_seen = 0;
            texts++;
         end
         if (step_chars.size() > 0)
            step_chars[step_chars.size()-1].run_last = 1;
         foreach (step_chars[i])
            expected_chars = {expected_chars, step_chars[i]};
      endfunction

      function void check_result(logic [15:0] code, logic subst, logic [1:0] kind,
                                 logic run_last, logic done);
         decoded_char_type want;
         if (expected_chars.size() == 0) begin
            errors++;
            $display("%0t: unexpected result code=%h subst=%b kind=%0d last=%b done=%b",
                     $time, code, subst, kind, run_last, done);
            return;
         end
         want = expected_chars.pop_front();
         checked++;
         if (code !== want.code || subst !== want.subst || kind !== want.kind ||
             run_last !== want.run_last || done !== want.done) begin
            errors++;
            $display("%0t: mismatch, expected code=%h subst=%b kind=%0d last=%b done=%b, %s",
                     $time, want.code, want.subst, want.kind, want.run_last, want.done,
                     $sformatf("actual code=%h subst=%b kind=%0d last=%b done=%b",
                               code, subst, kind, run_last, done));
         end
         if (subst === 1'b1)
            substs++;
         if (done === 1'b1 && kind !== 2'bxx && kind <= 2)
            final_kinds[kind]++;
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // data_byte
   logic        req_tlast = 1'b0;    // end_of_text
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;           // code_point
   logic [3:0]  rsp_tuser;           // substituted, script_kind[1:0], run_last
   logic        rsp_tlast;           // text_done

   script_decode_checker decode_sb = new();
   text_byte_type byte_plan[$];
   int unsigned stall_pct = 0;
   bit          hold_pending = 0;
   int unsigned idle_cycles = 0;

   // settings stamped onto each planned byte
   int unsigned plan_idle = 0;
   int unsigned plan_stall = 0;
   bit          plan_drain = 0;
   bit          plan_hold = 0;

   utf8_decode_script_classify dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            decode_sb.check_result(rsp_tdata, rsp_tuser[0], rsp_tuser[2:1], rsp_tuser[3],
                                   rsp_tlast);
         if (req_tvalid && req_tready)
            decode_sb.note_byte(req_tdata, req_tlast);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no request or result moved for %0d cycles", $time, IDLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // result side: random stalls, plus one long hold-off
   initial begin
      forever begin
         @(posedge clock);
         if (hold_pending) begin
            hold_pending = 0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_tready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   task automatic set_phase(int unsigned idle, int unsigned stall, bit drain, bit hold);
      plan_idle = idle;
      plan_stall = stall;
      plan_drain = drain;
      plan_hold = hold;
   endtask

   task automatic add_byte(logic [7:0] data, logic last);
      text_byte_type tb;
      tb.data = data;
      tb.last = last;
      tb.idle_pct = plan_idle;
      tb.stall_pct = plan_stall;
      tb.drain_first = plan_drain;
      tb.hold = plan_hold;
      plan_drain = 0;
      plan_hold = 0;
      byte_plan = {byte_plan, tb};
   endtask

   task automatic end_text();
      byte_plan[byte_plan.size()-1].last = 1'b1;
   endtask

   task automatic add_two_byte(logic [15:0] cp);
      add_byte({3'b110, cp[10:6]}, 1'b0);
      add_byte({2'b10, cp[5:0]}, 1'b0);
   endtask

   task automatic add_three_byte(logic [15:0] cp);
      add_byte({4'b1110, cp[15:12]}, 1'b0);
      add_byte({2'b10, cp[11:6]}, 1'b0);
      add_byte({2'b10, cp[5:0]}, 1'b0);
   endtask

   task automatic add_random_char();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 30) begin
         add_byte(8'($urandom_range(0, 127)), 1'b0);
      end else if (pick < 45) begin
         add_two_byte(16'($urandom_range(0, 16'h07FF)));
      end else if (pick < 55) begin
         add_two_byte(16'($urandom_range(16'h0400, 16'h04FF)));
      end else if (pick < 62) begin
         add_two_byte(16'($urandom_range(16'h0600, 16'h06FF)));
      end else if (pick < 70) begin
         add_three_byte(16'($urandom_range(16'hFB50, 16'hFEFF)));
      end else if (pick < 80) begin
         add_three_byte(16'($urandom_range(0, 16'hFFFF)));
      end else if (pick < 86) begin
         add_byte({2'b10, 6'($urandom_range(0, 63))}, 1'b0);
      end else if (pick < 90) begin
         add_byte({4'b1111, 4'($urandom_range(0, 15))}, 1'b0);
      end else if (pick < 96) begin
         // sequence cut short
         if ($urandom_range(1)) begin
            add_byte({3'b110, 5'($urandom_range(0, 31))}, 1'b0);
         end else begin
            add_byte({4'b1110, 4'($urandom_range(0, 15))}, 1'b0);
            if ($urandom_range(1))
               add_byte({2'b10, 6'($urandom_range(0, 63))}, 1'b0);
         end
      end else begin
         add_byte(8'($urandom_range(0, 255)), 1'b0);
      end
   endtask

   task automatic add_random_texts(int unsigned count);
      int unsigned target;
      target = byte_plan.size() + count;
      while (byte_plan.size() < target) begin
         repeat ($urandom_range(1, 10)) add_random_char();
         end_text();
      end
   endtask

   initial begin
      text_byte_type item;

      // cyrillic then arabic: arabic wins
      set_phase(0, 0, 0, 0);
      add_byte(8'h00, 1'b0);
      add_byte(8'h7F, 1'b0);
      add_two_byte(16'h0400);
      add_two_byte(16'h04FF);
      add_two_byte(16'h0600);
      add_byte(8'h41, 1'b1);
      // arabic range ends and presentation forms
      add_two_byte(16'h06FF);
      add_three_byte(16'hFB50);
      add_three_byte(16'hFEFF);
      end_text();
      // stray continuation, bad lead, broken sequences, cut off at end of text
      add_byte(8'h80, 1'b0);
      add_byte(8'hFF, 1'b0);
      add_byte(8'hE2, 1'b0);
      add_byte(8'h41, 1'b0);
      add_byte(8'hE2, 1'b0);
      add_byte(8'h82, 1'b0);
      add_byte(8'hF0, 1'b0);
      add_byte(8'hE2, 1'b0);
      add_byte(8'h82, 1'b0);
      add_byte(8'hC3, 1'b1);

      set_phase(0, 0, 1, 0);
      add_random_texts(PHASE_BYTES);
      set_phase(0, 0, 1, 1);
      add_random_texts(20);
      set_phase(70, 0, 1, 0);
      add_random_texts(PHASE_BYTES);
      set_phase(0, 70, 1, 0);
      add_random_texts(PHASE_BYTES);
      set_phase(33, 33, 1, 0);
      add_random_texts(PHASE_BYTES);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (byte_plan.size() > 0) begin
         item = byte_plan.pop_front();
         stall_pct = item.stall_pct;
         if (item.drain_first) begin
            req_tvalid <= 1'b0;
            do @(posedge clock); while (decode_sb.pending() != 0);
         end
         if (item.hold)
            hold_pending = 1;
         while ($urandom_range(99) < item.idle_pct) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata <= item.data;
         req_tlast <= item.last;
         do @(posedge clock); while (!req_tready);
      end
      req_tvalid <= 1'b0;

      do @(posedge clock); while (decode_sb.pending() != 0);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("%0d bytes in %0d texts, %0d results checked, %0d of them substituted",
               decode_sb.requests, decode_sb.texts, decode_sb.checked, decode_sb.substs);
      $display("texts ending latin/cyrillic/arabic: %0d/%0d/%0d",
               decode_sb.final_kinds[0], decode_sb.final_kinds[1], decode_sb.final_kinds[2]);
      if (decode_sb.errors == 0 && decode_sb.pending() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
